/* src/mbe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 23;
  localparam int INDEX_BITS = 13;
  localparam int ITER_BITS  = 16;
  localparam int RSQ_BITS   = 8;
  localparam int SCALE_BITS = 31;
  localparam int SIZE_BITS  = 13;

  localparam int OFF_W  = INDEX_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS;
  localparam int WIDE_W = 2 * COORD_BITS + 2;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  // register indexes, byte address = 4 * index
  localparam logic [2:0] REG_CENTER_X   = 3'd0;
  localparam logic [2:0] REG_CENTER_Y   = 3'd1;
  localparam logic [2:0] REG_PIXEL_SCL  = 3'd2;
  localparam logic [2:0] REG_MAX_ITER   = 3'd3;
  localparam logic [2:0] REG_ESC_RSQ    = 3'd4;
  localparam logic [2:0] REG_IMG_WIDTH  = 3'd5;
  localparam logic [2:0] REG_IMG_HEIGHT = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic [SCALE_BITS-1:0]        pixel_scale;
    logic [ITER_BITS-1:0]         max_iter;
    logic [RSQ_BITS-1:0]          escape_radius_sq;
    logic [SIZE_BITS-1:0]         image_width;
    logic [SIZE_BITS-1:0]         image_height;
  } cfg_t;

  typedef struct packed {
    logic in_load;   // capture pixel indices
    logic map_sel;   // multipliers take offset * scale
    logic prod_en;   // register the products
    logic load;      // c = centre + product, z = c, count = 0
    logic upd;       // z = z*z + c, count + 1
    logic out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic escape;      // |z|^2 above limit
    logic k_last;      // this step reaches max_iter
    logic maxit_zero;  // no step allowed
  } sts_t;

  // clamp a wide signed value to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if ((&v[WIDE_W-1:COORD_BITS-1]) || !(|v[WIDE_W-1:COORD_BITS-1])) begin
      r = v[COORD_BITS-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/mbe_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbe_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mbe_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [mbe_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [mbe_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready,
  output mbe_pkg::cfg_t                       cfg_o
);
  import mbe_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CENTER_X:   cfg_d.center_x         = $signed(pwdata[COORD_BITS-1:0]);
        REG_CENTER_Y:   cfg_d.center_y         = $signed(pwdata[COORD_BITS-1:0]);
        REG_PIXEL_SCL:  cfg_d.pixel_scale      = pwdata[SCALE_BITS-1:0];
        REG_MAX_ITER:   cfg_d.max_iter         = pwdata[ITER_BITS-1:0];
        REG_ESC_RSQ:    cfg_d.escape_radius_sq = pwdata[RSQ_BITS-1:0];
        REG_IMG_WIDTH:  cfg_d.image_width      = pwdata[SIZE_BITS-1:0];
        REG_IMG_HEIGHT: cfg_d.image_height     = pwdata[SIZE_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CENTER_X:   prdata = APB_DATA_W'(unsigned'(cfg_q.center_x));
      REG_CENTER_Y:   prdata = APB_DATA_W'(unsigned'(cfg_q.center_y));
      REG_PIXEL_SCL:  prdata = APB_DATA_W'(cfg_q.pixel_scale);
      REG_MAX_ITER:   prdata = APB_DATA_W'(cfg_q.max_iter);
      REG_ESC_RSQ:    prdata = APB_DATA_W'(cfg_q.escape_radius_sq);
      REG_IMG_WIDTH:  prdata = APB_DATA_W'(cfg_q.image_width);
      REG_IMG_HEIGHT: prdata = APB_DATA_W'(cfg_q.image_height);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x         <= -COORD_BITS'(32'sd5452595);
      cfg_q.center_y         <= '0;
      cfg_q.pixel_scale      <= SCALE_BITS'(6827);
      cfg_q.max_iter         <= ITER_BITS'(3000);
      cfg_q.escape_radius_sq <= RSQ_BITS'(100);
      cfg_q.image_width      <= SIZE_BITS'(4096);
      cfg_q.image_height     <= SIZE_BITS'(3072);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* src/mbe_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbe_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mbe_pkg::sts_t sts_i,
  output mbe_pkg::cmd_t      cmd_o
);
  import mbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_LOAD,
    S_MUL,
    S_UPD,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q, rdy_d;
  logic   vld_q, vld_d;
  logic   out_free;

  assign out_free = !vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    vld_d   = vld_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map_sel = 1'b1;
        cmd_o.prod_en = 1'b1;
        state_d       = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.maxit_zero ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd_o.prod_en = 1'b1;
        state_d       = S_UPD;
      end
      S_UPD: begin
        if (sts_i.escape) begin
          state_d = S_FIN;
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = sts_i.k_last ? S_FIN : S_MUL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          vld_d          = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    rdy_d = (state_d == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= rdy_d;
      vld_q   <= vld_d;
    end
  end

  assign in_ready_o  = rdy_q;
  assign out_valid_o = vld_q;

endmodule

`default_nettype wire

/* src/mbe_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbe_datapath (
  input  wire logic                           clk_i,
  input  wire mbe_pkg::cfg_t                  cfg_i,
  input  wire mbe_pkg::cmd_t                  cmd_i,
  output mbe_pkg::sts_t                       sts_o,
  input  wire logic [mbe_pkg::INDEX_BITS-1:0] row_i,
  input  wire logic [mbe_pkg::INDEX_BITS-1:0] col_i,
  output logic      [mbe_pkg::INDEX_BITS-1:0] out_row_o,
  output logic      [mbe_pkg::INDEX_BITS-1:0] out_col_o,
  output logic      [mbe_pkg::ITER_BITS-1:0]  out_iter_o
);
  import mbe_pkg::*;

  logic [INDEX_BITS-1:0] row_q, col_q, out_row_q, out_col_q;
  logic [ITER_BITS-1:0]  k_q, out_iter_q;

  logic signed [COORD_BITS-1:0] a_q, b_q, x_q, y_q;
  logic signed [PROD_W-1:0]     p0_q, p1_q, p2_q;

  logic signed [OFF_W-1:0]      off_col, off_row;
  logic signed [COORD_BITS-1:0] scale_s, op_a0, op_b0, op_a1, op_b1;
  logic signed [WIDE_W-1:0]     map_a, map_b, diff, xy2, x_new, y_new;
  logic        [WIDE_W-1:0]     mag, lim;

  // pixel offset from the image centre
  assign off_col = $signed({1'b0, col_q}) -
                   $signed(OFF_W'(cfg_i.image_width[SIZE_BITS-1:1]));
  assign off_row = $signed({1'b0, row_q}) -
                   $signed(OFF_W'(cfg_i.image_height[SIZE_BITS-1:1]));
  assign scale_s = $signed(COORD_BITS'(cfg_i.pixel_scale));

  // multipliers shared between mapping and iteration
  assign op_a0 = cmd_i.map_sel ? COORD_BITS'(off_col) : x_q;
  assign op_b0 = cmd_i.map_sel ? scale_s : x_q;
  assign op_a1 = cmd_i.map_sel ? COORD_BITS'(off_row) : y_q;
  assign op_b1 = cmd_i.map_sel ? scale_s : y_q;

  assign map_a = WIDE_W'(cfg_i.center_x) + WIDE_W'(p0_q);
  assign map_b = WIDE_W'(cfg_i.center_y) + WIDE_W'(p1_q);

  assign diff  = WIDE_W'(p0_q) - WIDE_W'(p1_q);
  assign xy2   = WIDE_W'(p2_q) <<< 1;
  assign x_new = (diff >>> FRAC_BITS) + WIDE_W'(a_q);
  assign y_new = (xy2 >>> FRAC_BITS) + WIDE_W'(b_q);

  // squares are non-negative, sum taken unsigned
  assign mag = {2'b00, p0_q} + {2'b00, p1_q};
  assign lim = WIDE_W'(cfg_i.escape_radius_sq) << (2 * FRAC_BITS);

  assign sts_o.escape     = mag > lim;
  assign sts_o.k_last     = ({1'b0, k_q} + (ITER_BITS+1)'(1)) >= {1'b0, cfg_i.max_iter};
  assign sts_o.maxit_zero = (cfg_i.max_iter == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      row_q <= row_i;
      col_q <= col_i;
    end
    if (cmd_i.prod_en) begin
      p0_q <= op_a0 * op_b0;
      p1_q <= op_a1 * op_b1;
      p2_q <= x_q * y_q;
    end
    if (cmd_i.load) begin
      a_q <= sat_coord(map_a);
      b_q <= sat_coord(map_b);
      x_q <= sat_coord(map_a);
      y_q <= sat_coord(map_b);
      k_q <= '0;
    end else if (cmd_i.upd) begin
      x_q <= sat_coord(x_new);
      y_q <= sat_coord(y_new);
      k_q <= k_q + ITER_BITS'(1);
    end
    if (cmd_i.out_load) begin
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_iter_q <= k_q;
    end
  end

  assign out_row_o  = out_row_q;
  assign out_col_o  = out_col_q;
  assign out_iter_o = out_iter_q;

endmodule

`default_nettype wire

/* src/mandelbrot_escape_time.sv */
// Mandelbrot escape-time evaluator. Each request on the input stream names a
// pixel (row, column); the block maps it to c = centre + (pixel - size/2) *
// scale in signed Q9.23, iterates z = z*z + c from z = c and returns the row,
// column and the number of steps done before |z|^2 exceeded the escape
// radius squared, or max_iter if it never did. One pixel is worked on at a
// time: a pixel goes through accept, offset multiply and centre add, then a
// multiply and an update per step through the three 32x32 multipliers (two
// of them shared with the mapping), then hand-off to the output register
// once it is free; a pixel that escapes after n steps needs one more
// multiply and test. The finished result waits in an output register, and
// the next request is taken as soon as it has moved there. Registers sit on
// the APB port at byte address 4*i; write them only while the block is
// idle.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [12:0] pixel_row, [25:13] pixel_col, [31:26] zero
  input  wire logic [mbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [12:0] out_row, [25:13] out_col, [41:26] iter_count, [47:42] zero
  output logic      [mbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mbe_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [mbe_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [mbe_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import mbe_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic [INDEX_BITS-1:0] out_row, out_col;
  logic [ITER_BITS-1:0]  out_iter;

  mbe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: one pixel at a time, escape test gates each step
  mbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // coordinates, products, step counter and output register
  mbe_datapath u_dp (
    .clk_i      (clk_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .row_i      (s_axis_tdata_i[INDEX_BITS-1:0]),
    .col_i      (s_axis_tdata_i[2*INDEX_BITS-1:INDEX_BITS]),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_iter_o (out_iter)
  );

  assign m_axis_tdata_o = {
    (OUT_TDATA_W - 2*INDEX_BITS - ITER_BITS)'(0), out_iter, out_col, out_row
  };

endmodule

`default_nettype wire

/* src/mbe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbe_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid_i,
  input wire logic                            s_axis_tready_o,
  input wire logic [mbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [mbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                            psel,
  input wire logic                            penable,
  input wire logic                            pwrite,
  input wire logic [mbe_pkg::APB_ADDR_W-1:0]  paddr,
  input wire logic [mbe_pkg::APB_DATA_W-1:0]  pwdata,
  input wire logic [mbe_pkg::APB_DATA_W-1:0]  prdata,
  input wire logic                            pready
);
  import mbe_pkg::*;

  localparam int ITER_LO = 2 * INDEX_BITS;

  logic [ITER_BITS-1:0] maxit_q;
  logic                 maxit_wr;

  assign maxit_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_ADDR_W-1:2] == REG_MAX_ITER);

  // shadow of the iteration limit, taken from the bus
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxit_q <= ITER_BITS'(3000);
    end else if (maxit_wr) begin
      maxit_q <= pwdata[ITER_BITS-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while a pixel is in flight");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[ITER_LO+ITER_BITS-1:ITER_LO] <= maxit_q)
    else $error("iteration count above limit");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps

// Bench for mandelbrot_escape_time: pixel requests go in on the slave stream,
// (row, col, step count) comes back on the master stream. A local predictor
// works out the step count of every accepted request from a mirror of the
// register set, and the monitor checks results in order against it.
module testbench;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int FRAC        = mbe_pkg::FRAC_BITS;

  typedef struct {
    logic [12:0] row;
    logic [12:0] col;
  } pixel_t;

  typedef struct {
    logic [12:0] row;
    logic [12:0] col;
    logic [15:0] steps;
  } pixel_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // request side
  logic        req_valid = 1'b0;
  logic        s_axis_tready_o;
  // [12:0] pixel_row, [25:13] pixel_col, [31:26] zero
  logic [31:0] req_data = '0;

  // result side
  logic        m_axis_tvalid_o;
  logic        res_ready = 1'b0;
  // [12:0] out_row, [25:13] out_col, [41:26] iter_count, [47:42] zero
  logic [47:0] m_axis_tdata_o;

  // config port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  mbe_pkg::cfg_t view;          // mirror of the register set
  pixel_t        pixels_to_send[$];
  pixel_result_t results_due[$];
  int unsigned   send_gap_pct   = 0;
  int unsigned   sink_stall_pct = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;

  mandelbrot_escape_time dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: fixed-point escape-time count
  // ---------------------------------------------------------------------------

  // clamp to the signed 32-bit coordinate range
  function automatic logic signed [31:0] clamp_coord(input logic signed [127:0] v);
    if (v > 128'sh7fffffff) return 32'sh7fffffff;
    if (v < -128'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // centre + (index - floor(size/2)) * scale, saturated
  function automatic logic signed [31:0] plane_coord(input logic signed [31:0] centre,
                                                     input logic [12:0] idx,
                                                     input logic [12:0] size,
                                                     input logic [30:0] scale);
    longint                off;
    longint                v;
    logic signed [127:0]   wide;
    off  = longint'(idx) - longint'(size >> 1);
    v    = longint'(centre) + off * longint'(scale);
    wide = 128'(v);
    return clamp_coord(wide);
  endfunction

  function automatic logic [15:0] escape_steps(input mbe_pkg::cfg_t c,
                                               input logic [12:0] row,
                                               input logic [12:0] col);
    logic signed [31:0]  x, y;
    logic signed [127:0] a_w, b_w, xw, yw, xx, yy, xy, lim;
    int unsigned         k;
    bit                  escaped;
    x   = plane_coord($signed(c.center_x), col, c.image_width, c.pixel_scale);
    y   = plane_coord($signed(c.center_y), row, c.image_height, c.pixel_scale);
    a_w = 128'(x);
    b_w = 128'(y);
    lim = {120'd0, c.escape_radius_sq};
    lim = lim <<< (2 * FRAC);
    k = 0;
    escaped = 1'b0;
    while (k < c.max_iter && !escaped) begin
      xw = 128'(x);
      yw = 128'(y);
      xx = xw * xw;
      yy = yw * yw;
      if (xx + yy > lim) begin
        escaped = 1'b1;
      end else begin
        xy = xw * yw;
        x  = clamp_coord(((xx - yy) >>> FRAC) + a_w);
        y  = clamp_coord(((xy + xy) >>> FRAC) + b_w);
        k++;
      end
    end
    return k[15:0];
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: presents the head of the queue, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_t        head;
    pixel_result_t due;
    bit            taken;
    if (rst_ni) begin
      taken = req_valid && s_axis_tready_o;
      if (taken) begin
        head      = pixels_to_send.pop_front();
        due.row   = head.row;
        due.col   = head.col;
        due.steps = escape_steps(view, head.row, head.col);
        results_due.push_back(due);
      end
      // a held request stays put; only decide afresh when the bus is free
      if (!req_valid || taken) begin
        if (pixels_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          req_valid <= 1'b1;
          req_data  <= {6'd0, pixels_to_send[0].col, pixels_to_send[0].row};
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: in-order compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pixel_result_t want;
    logic [12:0]   got_row, got_col;
    logic [15:0]   got_steps;
    if (rst_ni) begin
      if (m_axis_tvalid_o && res_ready) begin
        got_row   = m_axis_tdata_o[12:0];
        got_col   = m_axis_tdata_o[25:13];
        got_steps = m_axis_tdata_o[41:26];
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("result row %0d col %0d steps %0d with none due",
                                  got_row, got_col, got_steps));
        end else begin
          want = results_due.pop_front();
          if (got_row !== want.row)
            flag_mismatch($sformatf("row %0d, want %0d", got_row, want.row));
          if (got_col !== want.col)
            flag_mismatch($sformatf("col %0d, want %0d", got_col, want.col));
          if (got_steps !== want.steps)
            flag_mismatch($sformatf("pixel (%0d,%0d) steps %0d, want %0d",
                                    want.row, want.col, got_steps, want.steps));
        end
      end
      res_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // only ever called with nothing in flight
  task automatic load_view(input mbe_pkg::cfg_t v);
    apb_write(mbe_pkg::REG_CENTER_X,   v.center_x);
    apb_write(mbe_pkg::REG_CENTER_Y,   v.center_y);
    apb_write(mbe_pkg::REG_PIXEL_SCL,  {1'b0, v.pixel_scale});
    apb_write(mbe_pkg::REG_MAX_ITER,   {16'd0, v.max_iter});
    apb_write(mbe_pkg::REG_ESC_RSQ,    {24'd0, v.escape_radius_sq});
    apb_write(mbe_pkg::REG_IMG_WIDTH,  {19'd0, v.image_width});
    apb_write(mbe_pkg::REG_IMG_HEIGHT, {19'd0, v.image_height});
    view = v;
  endtask

  function automatic mbe_pkg::cfg_t make_view(input int cx, input int cy,
                                              input int unsigned scale,
                                              input int unsigned maxit,
                                              input int unsigned rsq,
                                              input int unsigned w,
                                              input int unsigned h);
    mbe_pkg::cfg_t v;
    v.center_x         = cx;
    v.center_y         = cy;
    v.pixel_scale      = scale[30:0];
    v.max_iter         = maxit[15:0];
    v.escape_radius_sq = rsq[7:0];
    v.image_width      = w[12:0];
    v.image_height     = h[12:0];
    return v;
  endfunction

  // mostly a small window round the main cardioid with a low step limit;
  // now and then anything the fields hold
  function automatic mbe_pkg::cfg_t random_view();
    mbe_pkg::cfg_t v;
    int unsigned   span;
    v.image_width  = 13'(($urandom_range(4) == 0) ? $urandom_range(8191, 1)
                                                  : $urandom_range(64, 1));
    v.image_height = 13'(($urandom_range(4) == 0) ? $urandom_range(8191, 1)
                                                  : $urandom_range(64, 1));
    span = (v.image_width > v.image_height) ? 32'(v.image_width) : 32'(v.image_height);
    if ($urandom_range(5) == 0) v.pixel_scale = 31'($urandom);
    else v.pixel_scale = 31'((32'd3 << FRAC) / span + $urandom_range(255));
    if ($urandom_range(7) == 0) begin
      v.center_x = $urandom;
      v.center_y = $urandom;
    end else begin
      v.center_x = int'($urandom_range(12582912)) - 10485760;  // -1.25 .. 0.25
      v.center_y = int'($urandom_range(8388608)) - 4194304;    // -0.5 .. 0.5
    end
    v.max_iter = 16'(($urandom_range(3) == 0) ? $urandom_range(400, 65)
                                              : $urandom_range(48, 1));
    v.escape_radius_sq = 8'(($urandom_range(7) == 0) ? $urandom_range(3)
                                                     : $urandom_range(255, 4));
    return v;
  endfunction

  task automatic queue_pixel(input int unsigned row, input int unsigned col);
    pixel_t p;
    p.row = row[12:0];
    p.col = col[12:0];
    pixels_to_send.push_back(p);
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_results();
    while (pixels_to_send.size() != 0 || results_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    mbe_pkg::cfg_t v;
    int unsigned   row, col;

    view = make_view(-5452595, 0, 6827, 3000, 100, 4096, 3072);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset view: centre pixel sits in the cardioid and runs to the limit,
    // corners escape, and an index past the image edge is used as is
    queue_pixel(1536, 2048);
    queue_pixel(0, 0);
    queue_pixel(8191, 8191);
    queue_pixel(1536, 0);
    queue_pixel(1000, 2500);
    drain_results();

    // zero step limit: every count is zero
    load_view(make_view(-5452595, 0, 6827, 0, 100, 4096, 3072));
    queue_pixel(0, 8191);
    queue_pixel(8191, 0);
    queue_pixel(1536, 2048);
    drain_results();

    // extreme centre and scale: c escapes before the first step, but at (4096, 4094) c is near zero
    load_view(make_view(32'sh7fffffff, 32'sh80000000, 32'h7fffffff, 65535, 255,
                        8191, 8191));
    queue_pixel(0, 0);
    queue_pixel(8191, 8191);
    queue_pixel(4095, 4095);
    queue_pixel(4096, 4094);
    drain_results();

    // c = 0 never escapes: count saturates at the full 16-bit limit
    load_view(make_view(0, 0, 0, 65535, 4, 0, 0));
    queue_pixel(0, 0);
    drain_results();

    // escape radius squared below four, down to zero
    load_view(make_view(0, 0, 32'd1 << 21, 9, 0, 3, 3));
    queue_pixel(1, 1);
    queue_pixel(1, 2);
    queue_pixel(0, 0);
    drain_results();
    load_view(make_view(0, 0, 32'd3 << 22, 20, 3, 3, 3));
    queue_pixel(1, 1);
    queue_pixel(1, 2);
    queue_pixel(0, 0);
    queue_pixel(2, 2);
    drain_results();

    // random views; idling pattern moves from slow sink to slow source to none
    for (int ph = 0; ph < 9; ph++) begin
      send_gap_pct   = (ph < 3) ? 9 : (ph < 6) ? 84 : 0;
      sink_stall_pct = (ph < 3) ? 84 : (ph < 6) ? 9 : 0;
      v = random_view();
      load_view(v);
      for (int n = 0; n < 19; n++) begin
        if (ph == 4 && n == 10) drain_results();
        if ($urandom_range(4) == 0) begin
          row = $urandom_range(8191);
          col = $urandom_range(8191);
        end else begin
          row = $urandom_range(v.image_height - 1);
          col = $urandom_range(v.image_width - 1);
        end
        queue_pixel(row, col);
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* mandelbrot_escape_time.f */
src/mbe_pkg.sv
src/mbe_cfg_regs.sv
src/mbe_ctrl.sv
src/mbe_datapath.sv
src/mandelbrot_escape_time.sv
src/mbe_checker.sv
bench/testbench.sv
